// ----- hdl/lvrt_pkg.sv -----
// package for the lvrt current reference block: types, constants, atan table
// depends on nothing
`default_nettype none
package lvrt_pkg;
   localparam int FracBits     = 14;
   localparam int CordicStages = 16;
   localparam int GainFrac     = 12;
   localparam int Guard        = 16;
   localparam int AtanLen      = 24;
   localparam logic signed [31:0] KinvQ30 = 32'sd652032874;
   localparam logic signed [19:0] OutMax = 20'sd131071;
   localparam logic signed [19:0] OutMin = -20'sd131072;

   typedef enum logic [2:0] {
      REG_GAIN  = 3'd0, REG_UPPER = 3'd1, REG_LOWER = 3'd2, REG_ILIM = 3'd3,
      REG_RATIO = 3'd4, REG_PACT  = 3'd5, REG_QREA  = 3'd6, REG_NONE = 3'd7
   } reg_index_type;

   typedef enum logic [2:0] {
      RGN_NORMAL = 3'd0, RGN_SUPPORT = 3'd1, RGN_CUT = 3'd2,
      RGN_CAP = 3'd3, RGN_BLOCKED = 3'd4
   } region_type;

   typedef struct packed {
      logic [15:0] gain;
      logic [15:0] upper;
      logic [15:0] lower;
      logic [16:0] ilim;
      logic [16:0] ratio;
      logic signed [17:0] pact;
      logic signed [17:0] qrea;
   } cfg_type;

   function automatic logic [31:0] atan_entry(input int i);
      logic [31:0] t [AtanLen];
      t = '{32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
            32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
            32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
            32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
            32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051};
      return t[i];
   endfunction

   function automatic logic signed [19:0] sat18(input logic signed [63:0] v);
      if (v > 64'(OutMax)) return OutMax;
      if (v < 64'(OutMin)) return OutMin;
      return v[19:0];
   endfunction
endpackage
`default_nettype wire

// ----- hdl/lvrt_div.sv -----
// pipelined restoring divider, one quotient bit per stage, unsigned magnitudes
// depends on lvrt_pkg
`default_nettype none
module lvrt_div import lvrt_pkg::*; #(
   parameter int NumW = 32,
   parameter int DenW = 16
) (
   input  wire logic            clock,
   input  wire logic            en,
   input  wire logic [NumW-1:0] num,
   input  wire logic [DenW-1:0] den,
   output logic      [NumW-1:0] quo
);
   logic [NumW-1:0] n_ff [NumW+1];
   logic [NumW-1:0] q_ff [NumW+1];
   logic [DenW:0]   r_ff [NumW+1];
   logic [DenW-1:0] d_ff [NumW+1];

   always_comb begin
      n_ff[0] = num; q_ff[0] = '0; r_ff[0] = '0; d_ff[0] = den;
   end

   for (genvar k = 0; k < NumW; k++) begin : g_st
      logic [DenW+1:0] rs;
      logic [DenW+1:0] df;
      assign rs = {r_ff[k], n_ff[k][NumW-1-k]};
      assign df = rs - {2'b00, d_ff[k]};
      always_ff @(posedge clock) begin
         if (en) begin
            n_ff[k+1] <= n_ff[k];
            d_ff[k+1] <= d_ff[k];
            if (!df[DenW+1]) begin
               r_ff[k+1] <= df[DenW:0];
               q_ff[k+1] <= q_ff[k] | (NumW'(1) << (NumW-1-k));
            end else begin
               r_ff[k+1] <= rs[DenW:0];
               q_ff[k+1] <= q_ff[k];
            end
         end
      end
   end
   assign quo = q_ff[NumW];
endmodule
`default_nettype wire

// ----- hdl/lvrt_sqrt.sv -----
// pipelined integer square root, one result bit per stage
// depends on lvrt_pkg
`default_nettype none
module lvrt_sqrt import lvrt_pkg::*; #(
   parameter int InW = 40
) (
   input  wire logic             clock,
   input  wire logic             en,
   input  wire logic [InW-1:0]   rad,
   output logic      [InW/2-1:0] root
);
   localparam int RW = InW / 2;
   logic [InW-1:0] n_ff [RW+1];
   logic [RW-1:0]  r_ff [RW+1];

   always_comb begin
      n_ff[0] = rad; r_ff[0] = '0;
   end

   for (genvar k = 0; k < RW; k++) begin : g_st
      logic [RW-1:0]  tr;
      logic [InW-1:0] sq;
      assign tr = r_ff[k] | (RW'(1) << (RW-1-k));
      assign sq = InW'(tr) * InW'(tr);
      always_ff @(posedge clock) begin
         if (en) begin
            n_ff[k+1] <= n_ff[k];
            r_ff[k+1] <= (sq <= n_ff[k]) ? tr : r_ff[k];
         end
      end
   end
   assign root = r_ff[RW];
endmodule
`default_nettype wire

// ----- hdl/lvrt_cordic.sv -----
// pipelined rotation cordic with prescale and output rounding
// depends on lvrt_pkg
`default_nettype none
module lvrt_cordic import lvrt_pkg::*; #(
   parameter int CORDIC_STAGES = lvrt_pkg::CordicStages
) (
   input  wire logic               clock,
   input  wire logic               en,
   input  wire logic signed [19:0] a,
   input  wire logic signed [19:0] b,
   input  wire logic signed [15:0] ang,
   output logic signed [19:0]      xo,
   output logic signed [19:0]      yo,
   output logic                    sat
);
   localparam int NS = (CORDIC_STAGES < AtanLen) ? CORDIC_STAGES : AtanLen;
   localparam logic signed [63:0] RndIn = 64'sd1 <<< (29 - Guard);
   logic signed [47:0] x_ff [NS+1];
   logic signed [47:0] y_ff [NS+1];
   logic signed [33:0] z_ff [NS+1];
   logic signed [63:0] pa, pb;
   logic signed [47:0] xi, yi;
   logic signed [33:0] zi;

   always_comb begin
      pa = (64'(a) * 64'(KinvQ30) + RndIn) >>> (30 - Guard);
      pb = (64'(b) * 64'(KinvQ30) + RndIn) >>> (30 - Guard);
      xi = pa[47:0]; yi = pb[47:0];
      zi = 34'(ang) <<< 16;
      if (zi > 34'sh40000000 || zi < -34'sh40000000) begin
         xi = -xi; yi = -yi;
         zi = (zi > 0) ? zi - 34'sh80000000 : zi + 34'sh80000000;
      end
   end
   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0] <= xi; y_ff[0] <= yi; z_ff[0] <= zi;
      end
   end

   for (genvar k = 0; k < NS; k++) begin : g_st
      always_ff @(posedge clock) begin
         if (en) begin
            if (z_ff[k] >= 0) begin
               x_ff[k+1] <= x_ff[k] - (y_ff[k] >>> k);
               y_ff[k+1] <= y_ff[k] + (x_ff[k] >>> k);
               z_ff[k+1] <= z_ff[k] - 34'(atan_entry(k));
            end else begin
               x_ff[k+1] <= x_ff[k] + (y_ff[k] >>> k);
               y_ff[k+1] <= y_ff[k] - (x_ff[k] >>> k);
               z_ff[k+1] <= z_ff[k] + 34'(atan_entry(k));
            end
         end
      end
   end

   logic signed [63:0] xr, yr;
   assign xr = (64'(x_ff[NS]) + (64'sd1 <<< (Guard-1))) >>> Guard;
   assign yr = (64'(y_ff[NS]) + (64'sd1 <<< (Guard-1))) >>> Guard;
   assign xo = sat18(xr);
   assign yo = sat18(yr);
   assign sat = (xr != 64'(xo)) || (yr != 64'(yo));
endmodule
`default_nettype wire

// ----- hdl/lvrt_current_reference.sv -----
// top level of the lvrt current reference: config registers, region logic,
// pipeline control; uses lvrt_pkg, lvrt_div, lvrt_sqrt, lvrt_cordic
//
// usage: csr_ writes set gain, band voltages, current limit, rating ratio and
// p/q; write them only while no sample is in flight. each req_ beat carries
// one voltage sample (volt_mag low 16 bits, volt_angle next 16) and yields
// exactly one rsp_ beat with the current phasor, region and saturated flag.
// one sample per cycle is taken while the pipeline is not stalled; a sample
// passes the input stages, the bit-per-stage divider chain, the limit register,
// the bit-per-stage square root chain, the rotation register, the cordic
// input register and its stages (at most 24), and the output register.
// the whole pipeline advances only when its last stage is empty or taken,
// so a stalled receiver holds every beat in place and req_tready drops.
// reset empties the pipeline and loads the register reset values.
`default_nettype none
module lvrt_current_reference import lvrt_pkg::*; #(
   parameter int CORDIC_STAGES = lvrt_pkg::CordicStages
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_data,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,  // volt_mag[15:0], volt_angle[31:16]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata   // current_real, current_imag, region, saturated
);
   localparam int NS   = (CORDIC_STAGES < AtanLen) ? CORDIC_STAGES : AtanLen;
   localparam int DivL = 32;
   localparam int SqL  = 20;
   localparam int Lat  = 2 + DivL + 1 + SqL + 1 + NS + 2;

   cfg_type cfg_ff;
   logic    en;
   logic [Lat-1:0] vld_ff;

   assign csr_ready  = 1'b1;
   assign en         = !vld_ff[Lat-1] || rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = vld_ff[Lat-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{gain: '0, upper: '0, lower: '0, ilim: '0, ratio: 17'd16384,
                     pact: '0, qrea: '0};
      end else if (csr_valid) begin
         case (reg_index_type'(csr_index))
            REG_GAIN:  cfg_ff.gain  <= csr_data[15:0];
            REG_UPPER: cfg_ff.upper <= csr_data[15:0];
            REG_LOWER: cfg_ff.lower <= csr_data[15:0];
            REG_ILIM:  cfg_ff.ilim  <= csr_data[16:0];
            REG_RATIO: cfg_ff.ratio <= csr_data[16:0];
            REG_PACT:  cfg_ff.pact  <= csr_data[17:0];
            REG_QREA:  cfg_ff.qrea  <= csr_data[17:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (en) vld_ff <= {vld_ff[Lat-2:0], req_tvalid};
   end

   // stage 1: region, support term product, limit product
   logic [15:0] v_in;
   logic signed [15:0] ang_in;
   assign v_in = req_tdata[15:0];
   assign ang_in = req_tdata[31:16];
   logic [2:0]  rg1_ff;
   logic [15:0] v1_ff;
   logic signed [15:0] an1_ff;
   logic [31:0] kd1_ff;
   logic [33:0] lm1_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         v1_ff  <= v_in;
         an1_ff <= ang_in;
         if (v_in >= cfg_ff.upper) rg1_ff <= RGN_NORMAL;
         else if (v_in > cfg_ff.lower) rg1_ff <= RGN_SUPPORT;
         else rg1_ff <= RGN_BLOCKED;
         kd1_ff <= 32'(cfg_ff.gain) * 32'(cfg_ff.upper - v_in);
         lm1_ff <= 34'(cfg_ff.ilim) * 34'(cfg_ff.ratio);
      end
   end

   // stage 2: term, limit; divider operands
   logic [48:0] tp;
   logic [63:0] tsh;
   logic [19:0] term2;
   assign tp = 49'(kd1_ff) * 49'(cfg_ff.ratio);
   assign tsh = 64'(tp) >> (GainFrac + 2*FracBits);
   assign term2 = (tsh > 64'd524284) ? 20'd524284 : tsh[19:0];
   logic [2:0]  rg2_ff;
   logic [15:0] v2_ff;
   logic signed [15:0] an2_ff;
   logic [19:0] tm2_ff;
   logic [19:0] lim2_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         rg2_ff <= rg1_ff; v2_ff <= v1_ff; an2_ff <= an1_ff;
         tm2_ff <= term2;
         lim2_ff <= 20'(lm1_ff >> FracBits);
      end
   end

   logic [31:0] np, nq, qp, qq;
   assign np = 32'(cfg_ff.pact[17] ? -36'(cfg_ff.pact) : 36'(cfg_ff.pact)) << FracBits;
   assign nq = 32'(cfg_ff.qrea[17] ? -36'(cfg_ff.qrea) : 36'(cfg_ff.qrea)) << FracBits;
   lvrt_div #(.NumW(32), .DenW(16)) u_dp (.clock, .en, .num(np), .den(v2_ff), .quo(qp));
   lvrt_div #(.NumW(32), .DenW(16)) u_dq (.clock, .en, .num(nq), .den(v2_ff), .quo(qq));

   // side delay for divider latency
   logic [2:0]  rgd_ff [DivL];
   logic [15:0] vd_ff  [DivL];
   logic signed [15:0] and_ff [DivL];
   logic [19:0] tmd_ff [DivL];
   logic [19:0] limd_ff [DivL];
   always_ff @(posedge clock) begin
      if (en) begin
         rgd_ff[0] <= rg2_ff; vd_ff[0] <= v2_ff; and_ff[0] <= an2_ff;
         tmd_ff[0] <= tm2_ff; limd_ff[0] <= lim2_ff;
         for (int k = 1; k < DivL; k++) begin
            rgd_ff[k] <= rgd_ff[k-1]; vd_ff[k] <= vd_ff[k-1]; and_ff[k] <= and_ff[k-1];
            tmd_ff[k] <= tmd_ff[k-1]; limd_ff[k] <= limd_ff[k-1];
         end
      end
   end

   // stage 3: signed quotients, support add, limit decision
   function automatic logic signed [19:0] fix_q(input logic signed [17:0] p,
         input logic [31:0] q, input logic [15:0] v, output logic f);
      logic signed [63:0] s;
      f = 1'b0;
      if (v == 0) begin
         f = 1'b1;
         return (p > 0) ? OutMax : (p < 0) ? OutMin : 20'sd0;
      end
      s = p[17] ? -64'(q) : 64'(q);
      if (s > 64'(OutMax) || s < 64'(OutMin)) f = 1'b1;
      return sat18(s);
   endfunction

   logic signed [19:0] id3, iq3, iqs;
   logic f3a, f3b, f3c;
   logic [2:0] rg3;
   logic signed [41:0] mag2, lim2sq;
   // the limit reaches about 2^20, so it needs a sign bit above 20 bits
   logic signed [20:0] lim3;
   logic signed [63:0] sum3;
   always_comb begin
      id3 = fix_q(cfg_ff.pact, qp, vd_ff[DivL-1], f3a);
      iq3 = fix_q(cfg_ff.qrea, qq, vd_ff[DivL-1], f3b);
      f3c = 1'b0;
      rg3 = rgd_ff[DivL-1];
      lim3 = 21'(limd_ff[DivL-1]);
      sum3 = 64'(iq3) + $signed(64'(tmd_ff[DivL-1]));
      iqs = iq3;
      if (rg3 == RGN_SUPPORT) begin
         iqs = sat18(sum3);
         f3c = sum3 > 64'(OutMax);
      end
      mag2 = 42'(id3) * 42'(id3) + 42'(iqs) * 42'(iqs);
      lim2sq = 42'(lim3) * 42'(lim3);
   end
   logic [2:0] rg4_ff;
   logic signed [19:0] id4_ff, iq4_ff;
   logic f4_ff;
   logic signed [41:0] d4_ff;
   logic signed [15:0] an4_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         an4_ff <= and_ff[DivL-1];
         f4_ff <= f3a | f3b | f3c;
         id4_ff <= id3; iq4_ff <= iqs;
         d4_ff <= lim2sq - 42'(iqs) * 42'(iqs);
         rg4_ff <= rg3;
         if (rg3 == RGN_SUPPORT) begin
            if (mag2 > lim2sq && iqs < lim3) rg4_ff <= RGN_CUT;
            else if (iqs > lim3) begin
               rg4_ff <= RGN_CAP; id4_ff <= '0; iq4_ff <= sat18(64'(lim3));
               if (lim3 > OutMax) f4_ff <= 1'b1;
            end
         end
      end
   end

   logic [19:0] rt;
   logic [39:0] rad;
   assign rad = d4_ff[41] ? '0 : d4_ff[39:0];
   lvrt_sqrt #(.InW(40)) u_sq (.clock, .en, .rad, .root(rt));

   logic [2:0]  rgs_ff [SqL];
   logic signed [19:0] ids_ff [SqL], iqs_ff [SqL];
   logic fs_ff [SqL], ng_ff [SqL];
   logic signed [15:0] ans_ff [SqL];
   always_ff @(posedge clock) begin
      if (en) begin
         rgs_ff[0] <= rg4_ff; ids_ff[0] <= id4_ff; iqs_ff[0] <= iq4_ff;
         fs_ff[0] <= f4_ff; ng_ff[0] <= d4_ff[41]; ans_ff[0] <= an4_ff;
         for (int k = 1; k < SqL; k++) begin
            rgs_ff[k] <= rgs_ff[k-1]; ids_ff[k] <= ids_ff[k-1]; iqs_ff[k] <= iqs_ff[k-1];
            fs_ff[k] <= fs_ff[k-1]; ng_ff[k] <= ng_ff[k-1]; ans_ff[k] <= ans_ff[k-1];
         end
      end
   end

   // stage 5: finalize id/iq, vector for rotation
   logic signed [19:0] idf, iqf, a5, b5;
   logic f5;
   always_comb begin
      idf = ids_ff[SqL-1]; iqf = iqs_ff[SqL-1]; f5 = fs_ff[SqL-1];
      if (rgs_ff[SqL-1] == RGN_CUT) begin
         if (ng_ff[SqL-1]) begin
            idf = '0; f5 = 1'b1;
         end else begin
            idf = sat18(64'(rt));
            if (64'(rt) > 64'(OutMax)) f5 = 1'b1;
         end
      end
      if (rgs_ff[SqL-1] == RGN_BLOCKED) begin
         idf = '0; iqf = '0; f5 = 1'b0;
      end
      a5 = iqf[19] ? -iqf : iqf;
      b5 = iqf[19] ? -idf : idf;
   end
   logic signed [19:0] a6_ff, b6_ff;
   logic signed [15:0] an6_ff;
   logic [2:0] rg6_ff [NS+2];
   logic f6_ff [NS+2];
   always_ff @(posedge clock) begin
      if (en) begin
         a6_ff <= a5; b6_ff <= b5; an6_ff <= ans_ff[SqL-1];
         rg6_ff[0] <= rgs_ff[SqL-1]; f6_ff[0] <= f5;
         for (int k = 1; k < NS+2; k++) begin
            rg6_ff[k] <= rg6_ff[k-1]; f6_ff[k] <= f6_ff[k-1];
         end
      end
   end

   logic signed [19:0] xo, yo;
   logic cs;
   lvrt_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cor (.clock, .en, .a(a6_ff),
      .b(b6_ff), .ang(an6_ff), .xo, .yo, .sat(cs));

   // cordic adds its input register plus NS stages
   logic [39:0] out_ff;
   always_ff @(posedge clock) begin
      if (en) out_ff <= {f6_ff[NS+1] | cs, rg6_ff[NS+1], yo[17:0], xo[17:0]};
   end
   assign rsp_tdata = out_ff;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed under stall");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready) else $error("pipeline blocked while empty");
   a_region: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[38:36] <= RGN_BLOCKED) else $error("bad region");
endmodule
`default_nettype wire
